### design/swtb_pkg.sv
// Shared constants and types for the software timer bank.
`timescale 1ns / 1ps

package swtb_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ALLOC    = 3'd1;
  localparam logic [2:0] CMD_RELEASE  = 3'd2;
  localparam logic [2:0] CMD_SET_ONE  = 3'd3;
  localparam logic [2:0] CMD_SET_INTV = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;

  typedef struct packed {
    logic        in_use;
    logic [31:0] count;
    logic [31:0] reload;
    logic        locked;
    logic        notify_on;
  } swtb_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    swtb_entry_t      data;
  } swtb_wr_t;

endpackage

### design/swtb_slot_store.sv
// Slot state store: one read port and one whole-entry write port.
`timescale 1ns / 1ps

module swtb_slot_store import swtb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_addr_i,
  output swtb_entry_t      rd_entry_o,
  input  swtb_wr_t         wr_i
);

  logic [SLOTS-1:0] in_use_q;
  logic [SLOTS-1:0] locked_q;
  logic [SLOTS-1:0] notify_q;
  logic [31:0]      count_q  [SLOTS];
  logic [31:0]      reload_q [SLOTS];

  // flags cleared at reset; count and reload are zeroed on every allocate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      locked_q <= '0;
      notify_q <= '0;
    end else if (wr_i.en) begin
      in_use_q[wr_i.addr] <= wr_i.data.in_use;
      locked_q[wr_i.addr] <= wr_i.data.locked;
      notify_q[wr_i.addr] <= wr_i.data.notify_on;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      count_q[wr_i.addr]  <= wr_i.data.count;
      reload_q[wr_i.addr] <= wr_i.data.reload;
    end
  end

  always_comb begin
    rd_entry_o.in_use    = in_use_q[rd_addr_i];
    rd_entry_o.count     = count_q[rd_addr_i];
    rd_entry_o.reload    = reload_q[rd_addr_i];
    rd_entry_o.locked    = locked_q[rd_addr_i];
    rd_entry_o.notify_on = notify_q[rd_addr_i];
  end

endmodule

### design/swtb_tick_unit.sv
// Shared decrement, zero-compare and reload unit for one slot per cycle.
`timescale 1ns / 1ps

module swtb_tick_unit import swtb_pkg::*; (
  input  swtb_entry_t entry_i,
  output logic [31:0] count_o,
  output logic        expired_o
);

  logic        running;
  logic [31:0] dec;

  always_comb begin
    running   = (entry_i.count != 32'd0);
    dec       = running ? (entry_i.count - 32'd1) : entry_i.count;
    expired_o = running && (dec == 32'd0) && entry_i.notify_on;
    if ((entry_i.reload != 32'd0) && (dec == 32'd0)) begin
      count_o = entry_i.reload;
    end else begin
      count_o = dec;
    end
  end

endmodule

### design/software_timer_bank_core.sv
// Top level of the software timer bank: command sequencer and result register.
`timescale 1ns / 1ps

// Command-driven bank of SLOTS down-counting timer slots.
// Input channel: a command transfer takes place on a rising edge with start_i
// high and busy_o low; cmd_i, slot_i, duration_i and notify_i are captured then.
// Output channel: every command yields one result, shown on status_o,
// slot_out_o, remaining_o and expired_mask_o for a single cycle with done_o
// high. The receiver cannot stall; the result must be taken in that cycle.
// Timing: release, set and clear execute at once, with no walk; done_o follows in
// the next cycle. Allocate walks the slots from 0 and stops at the first free
// one. Tick walks all SLOTS slots through the shared tick unit, one slot per
// cycle. busy_o is high only while executing, so a new command can be
// transferred in the cycle in which done_o shows the previous result.
// Reset: all slots free, unlocked and without notify, no result pending.
// Count and reload need no reset as allocate zeroes them before any use.

module software_timer_bank_core import swtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] duration_i,
  input  logic        notify_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_out_o,
  output logic [31:0] remaining_o,
  output logic [15:0] expired_mask_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]  cmd_q;
  logic [3:0]  slot_q;
  logic [31:0] dur_q;
  logic        notify_q;
  logic [15:0] mask_acc_q, mask_acc_d;

  logic        done_q;
  logic [1:0]  status_q;
  logic [3:0]  slot_out_q;
  logic [31:0] rem_q;
  logic [15:0] mask_q;

  // next-result values computed in the execute cycle
  logic        finish;
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic [31:0] res_rem;

  logic [IDX_W-1:0] rd_addr;
  swtb_entry_t      rd_entry;
  swtb_wr_t         wr;
  logic [31:0]      tick_count;
  logic             tick_exp;
  logic             walk;
  logic             last;
  logic             slot_ok;
  logic             valid;
  logic             accept;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign walk    = (cmd_q == CMD_TICK) || (cmd_q == CMD_ALLOC);
  assign rd_addr = walk ? idx_q : IDX_W'(slot_q);
  assign last    = (idx_q == IDX_W'(SLOTS - 1));
  assign slot_ok = (32'(slot_q) < 32'(SLOTS));
  assign valid   = slot_ok && rd_entry.in_use;

  swtb_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_i       (wr)
  );

  swtb_tick_unit u_tick (
    .entry_i   (rd_entry),
    .count_o   (tick_count),
    .expired_o (tick_exp)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    mask_acc_d = mask_acc_q;
    finish     = 1'b0;
    res_status = STAT_OK;
    res_slot   = slot_q;
    res_rem    = 32'd0;
    wr.en      = 1'b0;
    wr.addr    = rd_addr;
    wr.data    = rd_entry;

    if (accept) begin
      state_d    = ST_EXEC;
      idx_d      = '0;
      mask_acc_d = '0;
    end else if (state_q == ST_EXEC) begin
      case (cmd_q)
        CMD_TICK: begin
          if (rd_entry.in_use) begin
            wr.en         = 1'b1;
            wr.data.count = tick_count;
            if (tick_exp) begin
              mask_acc_d = mask_acc_q | (16'd1 << idx_q);
            end
          end
          idx_d  = idx_q + IDX_W'(1);
          finish = last;
        end
        CMD_ALLOC: begin
          if (!rd_entry.in_use) begin
            wr.en      = 1'b1;
            wr.data    = '0;
            wr.data.in_use = 1'b1;
            res_slot   = 4'(idx_q);
            finish     = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
            if (last) begin
              res_status = STAT_NO_SLOT;
              finish     = 1'b1;
            end
          end
        end
        CMD_RELEASE: begin
          finish = 1'b1;
          if (valid) begin
            wr.en          = 1'b1;
            wr.data.in_use = 1'b0;
          end else begin
            res_status = STAT_REJECTED;
          end
        end
        CMD_SET_ONE: begin
          finish = 1'b1;
          if (!valid || (dur_q == 32'd0)) begin
            res_status = STAT_REJECTED;
          end else if ((rd_entry.count == 32'd0) && !rd_entry.locked) begin
            wr.en             = 1'b1;
            wr.data.count     = dur_q;
            wr.data.locked    = 1'b1;
            wr.data.notify_on = notify_q;
            res_rem           = dur_q;
          end else begin
            // busy slot reports its count; idle locked slot is unlocked
            if (rd_entry.count == 32'd0) begin
              wr.en          = 1'b1;
              wr.data.locked = 1'b0;
            end
            res_rem = rd_entry.count;
          end
        end
        CMD_SET_INTV: begin
          finish = 1'b1;
          if (!valid || (dur_q == 32'd0) || !notify_q) begin
            res_status = STAT_REJECTED;
          end else begin
            wr.en             = 1'b1;
            wr.data.count     = dur_q;
            wr.data.reload    = dur_q;
            wr.data.notify_on = 1'b1;
          end
        end
        CMD_CLEAR: begin
          finish = 1'b1;
          if (valid) begin
            wr.en             = 1'b1;
            wr.data.count     = 32'd0;
            wr.data.reload    = 32'd0;
            wr.data.locked    = 1'b0;
            wr.data.notify_on = 1'b0;
          end else begin
            res_status = STAT_REJECTED;
          end
        end
        default: begin
          finish     = 1'b1;
          res_status = STAT_REJECTED;
        end
      endcase
      if (finish) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
    end
  end

  // command capture, walk index and result payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    mask_acc_q <= mask_acc_d;
    if (accept) begin
      cmd_q    <= cmd_i;
      slot_q   <= slot_i;
      dur_q    <= duration_i;
      notify_q <= notify_i;
    end
    if (finish) begin
      status_q   <= res_status;
      slot_out_q <= res_slot;
      rem_q      <= res_rem;
      mask_q     <= mask_acc_d;
    end
  end

  assign busy_o         = (state_q == ST_EXEC);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_out_o     = slot_out_q;
  assign remaining_o    = rem_q;
  assign expired_mask_o = mask_q;

  // result is only strobed once the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while sequencer busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command neither executing nor finished");

  a_mask_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (expired_mask_o != 16'd0)) |-> (cmd_q == CMD_TICK))
    else $error("expiry mask on a command other than tick");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == STAT_OK) || (status_o == STAT_NO_SLOT) ||
                (status_o == STAT_REJECTED)))
    else $error("undefined status code");

endmodule
